>>> rtl/sqs_pkg.sv
// sqs_pkg: shared types, codes and constant functions for the sorted sample store
// no dependencies; used by sqs_cell, sqs_or_tree and sorted_sample_quantile_store_top

package sqs_pkg;

  localparam int TIME_BITS = 48;
  localparam int CAP_W     = 7;
  localparam int COUNT_W   = 7;
  localparam int NUM_PICKS = 6;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_CLEAR  = 1'b1;

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic                 opcode;
    logic [TIME_BITS-1:0] sample_value;
  } op_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   entry_count;
    logic [TIME_BITS-1:0] value_min;
    logic [TIME_BITS-1:0] decile_low;
    logic [TIME_BITS-1:0] quartile_low;
    logic [TIME_BITS-1:0] median_value;
    logic [TIME_BITS-1:0] quartile_high;
    logic [TIME_BITS-1:0] decile_high;
    logic                 list_empty;
    logic                 insert_dropped;
  } stats_t;

  // what every cell sees from the controller
  typedef struct packed {
    logic                 insert;
    logic [TIME_BITS-1:0] value;
  } ins_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INDEX,
    ST_TREE,
    ST_LOAD
  } state_t;

  // floor(m/10) for m up to 136 via reciprocal 205/2048
  function automatic logic [7:0] div10(input logic [7:0] m);
    logic [15:0] p;
    p = 16'(m) * 16'd205;
    return 8'(p[15:11]);
  endfunction

  // node count of a reduction level with fan-in of eight
  function automatic int level_size(input int n, input int lv);
    int s;
    s = n;
    for (int i = 0; i < lv; i++) begin
      s = (s + 7) / 8;
    end
    return s;
  endfunction

  function automatic int tree_levels(input int n);
    int s;
    int l;
    s = n;
    l = 0;
    while (s > 1) begin
      s = (s + 7) / 8;
      l++;
    end
    if (l == 0) begin
      l = 1;
    end
    return l;
  endfunction

endpackage

>>> rtl/sqs_cell.sv
// sqs_cell: one slot of the sorted row, compares against the new sample and
// either keeps its value, takes the new sample or takes its left neighbor's value
// depends on sqs_pkg

module sqs_cell (
  input  logic                           clk,
  input  sqs_pkg::ins_cmd_t              cmd,
  input  logic                           live,
  input  logic                           left_lt,
  input  logic [sqs_pkg::TIME_BITS-1:0]  left_value,
  output logic [sqs_pkg::TIME_BITS-1:0]  value,
  output logic                           lt
);

  logic [sqs_pkg::TIME_BITS-1:0] value_next;

  assign lt = live && (value < cmd.value);

  always_comb begin
    priority if (!cmd.insert || lt) begin
      value_next = value;
    end else if (left_lt) begin
      value_next = cmd.value;
    end else begin
      // everything from the insert point up shifts one slot right
      value_next = left_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> rtl/sqs_or_tree.sv
// sqs_or_tree: registered or-reduction with fan-in eight, one register per level
// depends on sqs_pkg for the level sizing functions

module sqs_or_tree #(
  parameter int N = 64,
  parameter int W = 288
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);

  localparam int LEVELS = sqs_pkg::tree_levels(N);

  logic [W-1:0] node [1:LEVELS][N];

  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
    localparam int SZ  = sqs_pkg::level_size(N, lv);
    localparam int PSZ = sqs_pkg::level_size(N, lv - 1);
    for (genvar j = 0; j < N; j++) begin : g_node
      if (j < SZ) begin : g_live
        logic [W-1:0] kids [8];
        for (genvar c = 0; c < 8; c++) begin : g_kid
          if (8 * j + c < PSZ) begin : g_in
            if (lv == 1) begin : g_leaf
              assign kids[c] = leaf[8 * j + c];
            end else begin : g_inner
              assign kids[c] = node[lv - 1][8 * j + c];
            end
          end else begin : g_pad
            assign kids[c] = '0;
          end
        end
        always_ff @(posedge clk) begin
          node[lv][j] <= kids[0] | kids[1] | kids[2] | kids[3]
                       | kids[4] | kids[5] | kids[6] | kids[7];
        end
      end else begin : g_dead
        always_ff @(posedge clk) begin
          node[lv][j] <= '0;
        end
      end
    end
  end

  assign root = node[LEVELS][0];

endmodule

>>> rtl/sorted_sample_quantile_store_top.sv
// sorted_sample_quantile_store_top: sorted row of sample cells, quantile readout
// through a registered or-tree, apb capacity register and output register
// depends on sqs_pkg, sqs_cell, sqs_or_tree
// an accepted transaction passes the index state, the or-tree states and the load state,
//   which waits for the output register to be free; the insert itself lands in the cell row on acceptance
// a new transaction is taken only in idle, after the last one has been loaded into the output register
// reset: list empty, capacity 64, output empty; sample cells are not cleared

module sorted_sample_quantile_store_top #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sqs_pkg::op_item_t sample,
  output logic              stats_valid,
  input  logic              stats_ready,
  output sqs_pkg::stats_t   stats
);

  localparam int TB     = sqs_pkg::TIME_BITS;
  localparam int NP     = sqs_pkg::NUM_PICKS;
  localparam int MAXN   = (DEPTH < 127) ? DEPTH : 127;
  localparam int CW     = $clog2(MAXN + 1);
  localparam int XW     = $clog2(DEPTH + 1);
  localparam int LEVELS = sqs_pkg::tree_levels(DEPTH);
  localparam int TCW    = $clog2(LEVELS + 1);

  // configuration
  logic [sqs_pkg::CAP_W-1:0] capacity;
  logic [sqs_pkg::CAP_W-1:0] cap_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sqs_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr == sqs_pkg::ADDR_CAPACITY) begin
      capacity <= pwdata[sqs_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == sqs_pkg::ADDR_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

  assign cap_eff = (int'(capacity) > DEPTH) ? sqs_pkg::CAP_W'(DEPTH) : capacity;

  // control
  sqs_pkg::state_t state, state_next;
  logic [TCW-1:0]  tree_cnt;
  logic            accept, idx_load, load_out;
  logic [CW-1:0]   held;
  logic [sqs_pkg::CAP_W-1:0] held_ext;
  logic            usable, room;
  logic            dropped;
  logic            pick_ok;

  assign accept   = sample_valid && sample_ready;
  assign held_ext = sqs_pkg::CAP_W'(held);
  assign usable   = (cap_eff != '0) && (held_ext <= cap_eff);
  assign room     = usable && (held_ext < cap_eff);

  always_comb begin
    state_next = state;
    unique case (state)
      sqs_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = sqs_pkg::ST_INDEX;
        end
      end
      sqs_pkg::ST_INDEX: state_next = sqs_pkg::ST_TREE;
      sqs_pkg::ST_TREE: begin
        if (tree_cnt == TCW'(LEVELS - 1)) begin
          state_next = sqs_pkg::ST_LOAD;
        end
      end
      sqs_pkg::ST_LOAD: begin
        if (load_out) begin
          state_next = sqs_pkg::ST_IDLE;
        end
      end
      default: state_next = sqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = (state == sqs_pkg::ST_IDLE);
    idx_load     = (state == sqs_pkg::ST_INDEX);
    load_out     = (state == sqs_pkg::ST_LOAD) && (!stats_valid || stats_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sqs_pkg::ST_IDLE;
      tree_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == sqs_pkg::ST_TREE) begin
        tree_cnt <= tree_cnt + TCW'(1);
      end else begin
        tree_cnt <= '0;
      end
    end
  end

  // list length and drop flag
  sqs_pkg::ins_cmd_t cmd;

  assign cmd.insert = accept && (sample.opcode == sqs_pkg::OP_INSERT) && room;
  assign cmd.value  = sample.sample_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.insert) begin
      held <= held + CW'(1);
    end else if (accept && sample.opcode == sqs_pkg::OP_CLEAR && usable) begin
      held <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dropped <= (sample.opcode == sqs_pkg::OP_INSERT) && !room;
    end
  end

  // cell row
  logic [TB-1:0] cell_value [DEPTH];
  logic          cell_lt    [DEPTH];
  logic          cell_live  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_live[i] = XW'(i) < XW'(held);
    if (i == 0) begin : g_head
      sqs_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .live       (cell_live[i]),
        .left_lt    (1'b1),
        .left_value (cmd.value),
        .value      (cell_value[i]),
        .lt         (cell_lt[i])
      );
    end else begin : g_body
      sqs_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .live       (cell_live[i]),
        .left_lt    (cell_lt[i - 1]),
        .left_value (cell_value[i - 1]),
        .value      (cell_value[i]),
        .lt         (cell_lt[i])
      );
    end
  end

  // pick indices: 0, n/10, n/4, n/2, 3n/4, 9n/10
  logic [7:0]    n8;
  logic [9:0]    n3;
  logic [CW-1:0] pick_idx [NP];

  assign n8 = 8'(held);
  assign n3 = 10'(n8) * 10'd3;

  always_ff @(posedge clk) begin
    if (idx_load) begin
      pick_idx[0] <= '0;
      pick_idx[1] <= CW'(sqs_pkg::div10(n8));
      pick_idx[2] <= CW'(n8 >> 2);
      pick_idx[3] <= CW'(n8 >> 1);
      pick_idx[4] <= CW'(n3 >> 2);
      pick_idx[5] <= CW'(n8 - sqs_pkg::div10(n8 + 8'd9));
      pick_ok     <= usable && (held != '0);
    end
  end

  // each cell masks its value into the pick lanes it matches
  logic [NP*TB-1:0] leaf [DEPTH];
  logic [NP*TB-1:0] root;

  for (genvar i = 0; i < DEPTH; i++) begin : g_leaf
    for (genvar k = 0; k < NP; k++) begin : g_pick
      assign leaf[i][(NP-1-k)*TB +: TB] =
        (XW'(i) == XW'(pick_idx[k])) ? cell_value[i] : '0;
    end
  end

  sqs_or_tree #(
    .N (DEPTH),
    .W (NP * TB)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stats_valid <= 1'b0;
    end else if (load_out) begin
      stats_valid <= 1'b1;
    end else if (stats_ready) begin
      stats_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      stats.entry_count    <= sqs_pkg::COUNT_W'(held);
      stats.value_min      <= pick_ok ? root[(NP-1)*TB +: TB] : '1;
      stats.decile_low     <= pick_ok ? root[(NP-2)*TB +: TB] : '1;
      stats.quartile_low   <= pick_ok ? root[(NP-3)*TB +: TB] : '1;
      stats.median_value   <= pick_ok ? root[(NP-4)*TB +: TB] : '1;
      stats.quartile_high  <= pick_ok ? root[(NP-5)*TB +: TB] : '1;
      stats.decile_high    <= pick_ok ? root[(NP-6)*TB +: TB] : '1;
      stats.list_empty     <= !pick_ok;
      stats.insert_dropped <= dropped;
    end
  end

endmodule

>>> bench/sorted_sample_quantile_store_top_test.sv
// sorted_sample_quantile_store_top_test: self-checking bench for the sorted sample store
// drives sample transactions and apb capacity writes, checks every stats transaction
// depends on sqs_pkg and sorted_sample_quantile_store_top

module sorted_sample_quantile_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 120;
  localparam int NUM_PHASES    = 12;
  localparam logic [sqs_pkg::TIME_BITS-1:0] ALL_ONES = '1;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic                          op;
    logic [sqs_pkg::TIME_BITS-1:0] val;    // capacity on a ROW_CAP row
    bit                            typed;
    sqs_pkg::stats_t               want;
  } dir_row_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [1:0]        paddr        = sqs_pkg::ADDR_CAPACITY;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  sqs_pkg::op_item_t sample       = '0;
  logic              stats_valid;
  logic              stats_ready  = 1'b0;
  sqs_pkg::stats_t   stats;

  sorted_sample_quantile_store_top uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .stats_valid(stats_valid),
    .stats_ready(stats_ready),
    .stats(stats)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the sorted list and the capacity register
  logic [sqs_pkg::TIME_BITS-1:0] held_samples [SLOTS];
  int                            held_n  = 0;
  logic [sqs_pkg::CAP_W-1:0]     cap_reg = sqs_pkg::CAP_RESET;

  sqs_pkg::stats_t awaited_stats [$];
  dir_row_t        dir_rows [$];

  int bad_count     = 0;
  int checked_count = 0;
  int offered_count = 0;
  int drop_count    = 0;
  int clear_count   = 0;
  int cap_writes    = 0;
  bit idling        = 1'b1;
  int hold_req      = 0;
  int hold_done     = 0;
  int unsigned rx_wait = 0;
  int unsigned cycles  = 0;

  function automatic logic [sqs_pkg::TIME_BITS-1:0] rank_at(int idx, bit ok);
    return ok ? held_samples[idx] : ALL_ONES;
  endfunction

  function automatic sqs_pkg::stats_t apply_sample_op(sqs_pkg::op_item_t it);
    sqs_pkg::stats_t r;
    int              lim;
    int              pos;
    bit              ok;
    lim = (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
    ok  = lim > 0 && held_n <= lim;
    r.insert_dropped = 1'b0;
    if (it.opcode == sqs_pkg::OP_CLEAR) begin
      if (ok) begin
        held_n = 0;
        clear_count++;
      end
    end else if (ok && held_n < lim) begin
      pos = 0;
      while (pos < held_n && held_samples[pos] < it.sample_value) pos++;
      for (int k = held_n; k > pos; k--) held_samples[k] = held_samples[k-1];
      held_samples[pos] = it.sample_value;
      held_n++;
    end else begin
      r.insert_dropped = 1'b1;
      drop_count++;
    end
    // usability cannot change within one transaction, only the count
    ok = ok && held_n > 0;
    r.entry_count   = sqs_pkg::COUNT_W'(held_n);
    r.value_min     = rank_at(0, ok);
    r.decile_low    = rank_at(held_n / 10, ok);
    r.quartile_low  = rank_at(held_n / 4, ok);
    r.median_value  = rank_at(held_n / 2, ok);
    r.quartile_high = rank_at((3 * held_n) / 4, ok);
    r.decile_high   = rank_at((9 * held_n) / 10, ok);
    r.list_empty    = !ok;
    return r;
  endfunction

  // every pick equal to v, or all ones when the list reads as empty
  function automatic sqs_pkg::stats_t typed_stats(int cnt, logic [sqs_pkg::TIME_BITS-1:0] v,
                                                  bit empty, bit drop);
    sqs_pkg::stats_t r;
    r.entry_count    = sqs_pkg::COUNT_W'(cnt);
    r.value_min      = empty ? ALL_ONES : v;
    r.decile_low     = r.value_min;
    r.quartile_low   = r.value_min;
    r.median_value   = r.value_min;
    r.quartile_high  = r.value_min;
    r.decile_high    = r.value_min;
    r.list_empty     = empty;
    r.insert_dropped = drop;
    return r;
  endfunction

  function automatic logic [sqs_pkg::TIME_BITS-1:0] pick_sample();
    logic [sqs_pkg::TIME_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? ALL_ONES : '0;
      1, 2: v = sqs_pkg::TIME_BITS'($urandom_range(0, 15));
      default: v = sqs_pkg::TIME_BITS'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  task automatic add_row(row_kind_t kind, logic op, logic [sqs_pkg::TIME_BITS-1:0] val,
                         bit typed, sqs_pkg::stats_t want);
    dir_row_t r;
    r.kind  = kind;
    r.op    = op;
    r.val   = val;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      bad_count++;
      if (bad_count <= 10) begin
        $display("mismatch in %s of stats %0d: expected %h, got %h",
                 name, checked_count, want, got);
      end
    end
  endtask

  // holds valid high until accepted; the caller lowers it when a gap follows
  task automatic offer(sqs_pkg::op_item_t it, bit typed, sqs_pkg::stats_t want);
    sqs_pkg::stats_t pred;
    sample       <= it;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    pred = apply_sample_op(it);
    awaited_stats.push_back(typed ? want : pred);
    offered_count++;
  endtask

  task automatic drain_stats();
    sample_valid <= 1'b0;
    while (awaited_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(logic [sqs_pkg::CAP_W-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= sqs_pkg::ADDR_CAPACITY;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = v;
    cap_writes++;
  endtask

  // stats receiver: random stall bursts plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      stats_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait--;
      stats_ready <= 1'b0;
    end else if (hold_done != hold_req) begin
      hold_done++;
      rx_wait = LONG_HOLD - 1;
      stats_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      rx_wait = $urandom_range(0, 6);
      stats_ready <= 1'b0;
    end else begin
      stats_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sqs_pkg::stats_t want;
    if (!rst && stats_valid && stats_ready) begin
      if (awaited_stats.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("stats transaction with nothing expected: %h", stats);
      end else begin
        want = awaited_stats.pop_front();
        check_field("entry_count", 64'(want.entry_count), 64'(stats.entry_count));
        check_field("value_min", 64'(want.value_min), 64'(stats.value_min));
        check_field("decile_low", 64'(want.decile_low), 64'(stats.decile_low));
        check_field("quartile_low", 64'(want.quartile_low), 64'(stats.quartile_low));
        check_field("median_value", 64'(want.median_value), 64'(stats.median_value));
        check_field("quartile_high", 64'(want.quartile_high), 64'(stats.quartile_high));
        check_field("decile_high", 64'(want.decile_high), 64'(stats.decile_high));
        check_field("list_empty", 64'(want.list_empty), 64'(stats.list_empty));
        check_field("insert_dropped", 64'(want.insert_dropped), 64'(stats.insert_dropped));
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d stats outstanding", awaited_stats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sqs_pkg::op_item_t         it;
    logic [sqs_pkg::CAP_W-1:0] cap_pick;
    int                        n_items;
    sqs_pkg::stats_t           no_want;

    no_want = '0;
    // reset state, equal samples, extremes of the value range
    add_row(ROW_ITEM, sqs_pkg::OP_CLEAR, 48'h1234_5678_9ABC, 1'b1,
            typed_stats(0, '0, 1'b1, 1'b0));
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, '0, 1'b1, typed_stats(1, '0, 1'b0, 1'b0));
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, '0, 1'b1, typed_stats(2, '0, 1'b0, 1'b0));
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, ALL_ONES, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'hAAAA_AAAA_AAAA, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'h5555_5555_5555, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_CLEAR, 48'hFFFF_0000_FFFF, 1'b1,
            typed_stats(0, '0, 1'b1, 1'b0));
    // capacity 0 disables: insert dropped, clear ignored
    add_row(ROW_CAP, sqs_pkg::OP_INSERT, 48'd0, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd7, 1'b1, typed_stats(0, '0, 1'b1, 1'b1));
    add_row(ROW_ITEM, sqs_pkg::OP_CLEAR, '0, 1'b1, typed_stats(0, '0, 1'b1, 1'b0));
    // one slot: second insert finds the list full
    add_row(ROW_CAP, sqs_pkg::OP_INSERT, 48'd1, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'h8000_0000_0000, 1'b1,
            typed_stats(1, 48'h8000_0000_0000, 1'b0, 1'b0));
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd1, 1'b1,
            typed_stats(1, 48'h8000_0000_0000, 1'b0, 1'b1));
    // capacity above the slot count saturates
    add_row(ROW_CAP, sqs_pkg::OP_INSERT, 48'd127, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd5, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd3, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd9, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd3, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFE, 1'b0, no_want);
    // capacity below the count disables until raised again
    add_row(ROW_CAP, sqs_pkg::OP_INSERT, 48'd2, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd4, 1'b1, typed_stats(6, '0, 1'b1, 1'b1));
    add_row(ROW_ITEM, sqs_pkg::OP_CLEAR, '0, 1'b1, typed_stats(6, '0, 1'b1, 1'b0));
    add_row(ROW_CAP, sqs_pkg::OP_INSERT, 48'd6, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_INSERT, 48'd2, 1'b0, no_want);
    add_row(ROW_ITEM, sqs_pkg::OP_CLEAR, '0, 1'b1, typed_stats(0, '0, 1'b1, 1'b0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        drain_stats();
        write_cap(dir_rows[i].val[sqs_pkg::CAP_W-1:0]);
      end else begin
        it.opcode       = dir_rows[i].op;
        it.sample_value = dir_rows[i].val;
        offer(it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_stats();
      // bring the list back to a usable empty state now and then
      if (ph >= 4 && ph % 2 == 0) begin
        write_cap(sqs_pkg::CAP_RESET);
        it.opcode       = sqs_pkg::OP_CLEAR;
        it.sample_value = pick_sample();
        offer(it, 1'b0, no_want);
        drain_stats();
      end
      case (ph)
        0: cap_pick = 7'd64;
        1: cap_pick = 7'd127;
        2: cap_pick = 7'd1;
        3: cap_pick = 7'd0;
        NUM_PHASES - 1: cap_pick = 7'd64;
        default: cap_pick = sqs_pkg::CAP_W'($urandom_range(0, 127));
      endcase
      write_cap(cap_pick);
      idling  = (ph % 4 != 3) && ph < NUM_PHASES - 2;
      n_items = (ph == 0) ? 80 : 60;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 5 && i == 10) hold_req++;
        if (ph == 6 && i == 30) drain_stats();
        if (idling && $urandom_range(0, 3) == 0) begin
          sample_valid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        it.opcode       = (ph != 0 && $urandom_range(0, 39) == 0) ? sqs_pkg::OP_CLEAR
                                                                 : sqs_pkg::OP_INSERT;
        it.sample_value = pick_sample();
        offer(it, 1'b0, no_want);
      end
    end

    drain_stats();
    $display("%0d sample transactions, %0d stats checked, %0d capacity writes",
             offered_count, checked_count, cap_writes);
    $display("%0d inserts dropped on a full or disabled list, %0d clears taken",
             drop_count, clear_count);
    if (bad_count == 0 && awaited_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", bad_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sqs_pkg.sv
rtl/sqs_cell.sv
rtl/sqs_or_tree.sv
rtl/sorted_sample_quantile_store_top.sv
bench/sorted_sample_quantile_store_top_test.sv
